// ===== sv/cmp3_pkg.sv =====
// Shared types, constants and helper functions of the cosine motion profile block.
`default_nettype none

package cmp3_pkg;

   localparam int DEF_CORDIC_ITERATIONS = 16;
   localparam int DEF_FRAC_BITS         = 16;

   localparam int COORD_W = 32;
   localparam int HP_W    = 31;
   localparam int TIME_W  = 32;
   localparam int CT_W    = 33;
   localparam int TRIG_W  = 34;
   localparam int IDX_CFG_W = 3;
   localparam int STEP_W  = 7;

   // Register indexes of the configuration port.
   localparam logic [IDX_CFG_W-1:0] REG_START_X     = 3'd0;
   localparam logic [IDX_CFG_W-1:0] REG_START_Y     = 3'd1;
   localparam logic [IDX_CFG_W-1:0] REG_START_Z     = 3'd2;
   localparam logic [IDX_CFG_W-1:0] REG_END_X       = 3'd3;
   localparam logic [IDX_CFG_W-1:0] REG_END_Y       = 3'd4;
   localparam logic [IDX_CFG_W-1:0] REG_END_Z       = 3'd5;
   localparam logic [IDX_CFG_W-1:0] REG_HALF_PERIOD = 3'd6;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [31:0] PI2_Q28 = 32'd2649351758;
   localparam logic signed [TRIG_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
   localparam logic signed [TRIG_W-1:0] ONE_Q30      = 34'sd1073741824;
   localparam logic [29:0] HALF_Q30 = 30'h2000_0000;

   // Step counts of the shared divider for each kind of division.
   localparam logic [STEP_W-1:0] STEPS_MOD  = 7'd33;
   localparam logic [STEP_W-1:0] STEPS_FRAC = 7'd61;
   localparam logic [STEP_W-1:0] STEPS_FULL = 7'd64;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_PHASE,
      ST_FRAC_WAIT,
      ST_TH_MUL,
      ST_TH_RND,
      ST_CORDIC_WAIT,
      ST_AX_DIFF,
      ST_POS_MUL,
      ST_POS_RND,
      ST_VEL_MUL1,
      ST_VEL_RND1,
      ST_VEL_MUL2,
      ST_VEL_RND2,
      ST_VEL_DIV,
      ST_VEL_WAIT,
      ST_ACC_MUL1,
      ST_ACC_RND1,
      ST_ACC_MUL2,
      ST_ACC_RND2,
      ST_ACC_DIV1,
      ST_ACC_WAIT1,
      ST_ACC_DIV2,
      ST_ACC_WAIT2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [63:0]       dividend;
      logic [31:0]       divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000007;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   // Adds half an LSB of the target scale and drops the low bits.
   function automatic logic [63:0] round_shift(input logic [63:0] p, input int unsigned sh);
      logic [64:0] s;
      s = {1'b0, p} + (65'd1 << (sh - 1));
      return 64'(s >> sh);
   endfunction

endpackage

`default_nettype wire

// ===== sv/cmp3_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module cmp3_div import cmp3_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output      div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [63:0]       quo_ff, quo_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       dsr_ff, dsr_in;

   always_comb begin
      logic [32:0] shifted;
      logic [32:0] diff;
      shifted  = {rem_ff, quo_ff[63]};
      diff     = shifted - {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = req.steps;
         quo_in   = req.dividend;
         rem_in   = '0;
         dsr_in   = req.divisor;
      end else if (busy_ff) begin
         // The dividend sits left-aligned, so quotient bits fill in from the bottom.
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

   assert property (@(posedge clock) disable iff (reset) req.start |-> !busy_ff)
      else $error("divider started while a division is in progress");

   assert property (@(posedge clock) disable iff (reset) done_ff |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below the divisor");

endmodule

`default_nettype wire

// ===== sv/cmp3_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`default_nettype none

module cmp3_cordic import cmp3_pkg::*; #(
   parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [TRIG_W-1:0] z_init,
   output      logic                     done,
   output      logic signed [TRIG_W-1:0] x_out,
   output      logic signed [TRIG_W-1:0] y_out
);

   localparam int NSTEP = (CORDIC_ITERATIONS > 30) ? 30 : CORDIC_ITERATIONS;
   localparam int IDX_W = $clog2(NSTEP);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [TRIG_W-1:0] x_ff, x_in;
   logic signed [TRIG_W-1:0] y_ff, y_in;
   logic signed [TRIG_W-1:0] z_ff, z_in;

   always_comb begin
      logic signed [TRIG_W-1:0] xs;
      logic signed [TRIG_W-1:0] ys;
      logic signed [TRIG_W-1:0] ang;
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      ang     = signed'(TRIG_W'(atan_q30(5'(idx_ff))));
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         x_in    = GAIN_INV_Q30;
         y_in    = '0;
         z_in    = z_init;
      end else if (busy_ff) begin
         if (!z_ff[TRIG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IDX_W'(NSTEP - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

`default_nettype wire

// ===== sv/cosine_motion_profile_3axis_unit.sv =====
// Top level of the 3-axis raised-cosine motion profile generator.
//
// Usage: write start, end and half period through the csr_ port while the
// block is idle. Each transfer on the req_ channel carries the time elapsed
// since the previous one; the block adds it to its cycle time, reduced
// modulo twice the half period, and returns one rsp_ transfer with position,
// velocity and acceleration for x, y and z, all signed Q16.16, saturated.
// One item is worked on at a time. The block is back in idle when rsp_valid
// rises and takes a waiting item while the result sits in the output
// register. The one shared divider produces one quotient bit per cycle and
// runs eleven divisions per item, nine of them 64 bits deep.
// Multiplies go through one 32x32 multiplier with a registered product.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the finished next item in the last
// state until the output register frees up. Reset clears the cycle time and
// loads the default configuration: start at the origin, end at x = 1.0 and
// a half period of 2.0 s.
`default_nettype none

module cosine_motion_profile_3axis_unit import cmp3_pkg::*; #(
   parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS,
   parameter int FRAC_BITS         = DEF_FRAC_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [IDX_CFG_W-1:0]      csr_index,
   input  wire logic [COORD_W-1:0]        csr_wdata,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [TIME_W-1:0]         req_time_step,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic signed [COORD_W-1:0] rsp_pos_x,
   output      logic signed [COORD_W-1:0] rsp_pos_y,
   output      logic signed [COORD_W-1:0] rsp_pos_z,
   output      logic signed [COORD_W-1:0] rsp_vel_x,
   output      logic signed [COORD_W-1:0] rsp_vel_y,
   output      logic signed [COORD_W-1:0] rsp_vel_z,
   output      logic signed [COORD_W-1:0] rsp_acc_x,
   output      logic signed [COORD_W-1:0] rsp_acc_y,
   output      logic signed [COORD_W-1:0] rsp_acc_z
);

   state_type state_ff, state_in;

   logic signed [COORD_W-1:0] start_ff [3];
   logic signed [COORD_W-1:0] end_ff [3];
   logic [HP_W-1:0]           hp_cfg_ff;
   logic [CT_W-1:0]           cycle_time_ff, cycle_time_in;

   logic [HP_W-1:0]           hp_ff, hp_in;
   logic [CT_W-1:0]           sum_ff, sum_in;
   logic                      back_ff, back_in;
   logic [29:0]               mag_ff, mag_in;
   logic                      gneg_ff, gneg_in;
   logic signed [31:0]        sin_ff, sin_in;
   logic signed [31:0]        cos_ff, cos_in;
   logic [1:0]                axis_ff, axis_in;
   logic [31:0]               dm_ff, dm_in;
   logic                      dn_ff, dn_in;
   logic [35:0]               m_ff, m_in;
   logic [63:0]               q1_ff, q1_in;
   logic                      big_ff, big_in;
   logic [63:0]               prod_ff;
   logic [31:0]               mul_a, mul_b;
   logic signed [COORD_W-1:0] pos_ff [3], pos_in [3];
   logic signed [COORD_W-1:0] vel_ff [3], vel_in [3];
   logic signed [COORD_W-1:0] acc_ff [3], acc_in [3];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] out_pos_ff [3], out_vel_ff [3], out_acc_ff [3];
   logic                      load_out;

   div_req_type               div_req;
   div_rsp_type               div_rsp;
   logic                      cordic_start;
   logic signed [TRIG_W-1:0]  cordic_z;
   logic                      cordic_done;
   logic signed [TRIG_W-1:0]  cordic_x, cordic_y;

   function automatic logic signed [31:0] clamp_unit(input logic signed [TRIG_W-1:0] v);
      if (v > ONE_Q30) begin
         return 32'sh4000_0000;
      end
      if (v < -ONE_Q30) begin
         return -32'sh4000_0000;
      end
      return v[31:0];
   endfunction

   // Signs a magnitude and saturates it to the 32-bit range.
   function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] q,
                                                  input logic force_sat);
      if (neg) begin
         if (force_sat || q > 64'h8000_0000) begin
            return 32'sh8000_0000;
         end
         return 32'(-q[31:0]);
      end
      if (force_sat || q > 64'h7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end
      return q[31:0];
   endfunction

   cmp3_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cmp3_cordic #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .z_init (cordic_z),
      .done   (cordic_done),
      .x_out  (cordic_x),
      .y_out  (cordic_y)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_MOD_START;
         ST_MOD_START:   state_in = ST_MOD_WAIT;
         ST_MOD_WAIT:    if (div_rsp.done) state_in = ST_PHASE;
         ST_PHASE:       state_in = ST_FRAC_WAIT;
         ST_FRAC_WAIT:   if (div_rsp.done) state_in = ST_TH_MUL;
         ST_TH_MUL:      state_in = ST_TH_RND;
         ST_TH_RND:      state_in = ST_CORDIC_WAIT;
         ST_CORDIC_WAIT: if (cordic_done) state_in = ST_AX_DIFF;
         ST_AX_DIFF:     state_in = ST_POS_MUL;
         ST_POS_MUL:     state_in = ST_POS_RND;
         ST_POS_RND:     state_in = ST_VEL_MUL1;
         ST_VEL_MUL1:    state_in = ST_VEL_RND1;
         ST_VEL_RND1:    state_in = ST_VEL_MUL2;
         ST_VEL_MUL2:    state_in = ST_VEL_RND2;
         ST_VEL_RND2:    state_in = ST_VEL_DIV;
         ST_VEL_DIV:     state_in = ST_VEL_WAIT;
         ST_VEL_WAIT:    if (div_rsp.done) state_in = ST_ACC_MUL1;
         ST_ACC_MUL1:    state_in = ST_ACC_RND1;
         ST_ACC_RND1:    state_in = ST_ACC_MUL2;
         ST_ACC_MUL2:    state_in = ST_ACC_RND2;
         ST_ACC_RND2:    state_in = ST_ACC_DIV1;
         ST_ACC_DIV1:    state_in = ST_ACC_WAIT1;
         ST_ACC_WAIT1:   if (div_rsp.done) state_in = ST_ACC_DIV2;
         ST_ACC_DIV2:    state_in = ST_ACC_WAIT2;
         ST_ACC_WAIT2: begin
            if (div_rsp.done) begin
               state_in = (axis_ff == 2'd2) ? ST_DONE : ST_AX_DIFF;
            end
         end
         ST_DONE:        if (load_out) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic              back_c;
      logic [CT_W-1:0]   tau_c;
      logic [63:0]       rnd_c;
      logic [31:0]       th_c;
      logic [32:0]       g_c;
      logic signed [32:0] d_c;
      logic signed [34:0] sm_c;
      logic signed [34:0] p_c;
      logic [32:0]       omc_c;
      logic              neg_c;
      logic [63:0]       q_c;

      back_c = cycle_time_ff > {2'b00, hp_ff};
      tau_c  = back_c ? (cycle_time_ff - {2'b00, hp_ff}) : cycle_time_ff;
      rnd_c  = '0;
      th_c   = '0;
      g_c    = '0;
      d_c    = '0;
      sm_c   = '0;
      p_c    = '0;
      omc_c  = '0;
      neg_c  = 1'b0;
      q_c    = div_rsp.quotient;

      cycle_time_in = cycle_time_ff;
      hp_in   = hp_ff;
      sum_in  = sum_ff;
      back_in = back_ff;
      mag_in  = mag_ff;
      gneg_in = gneg_ff;
      sin_in  = sin_ff;
      cos_in  = cos_ff;
      axis_in = axis_ff;
      dm_in   = dm_ff;
      dn_in   = dn_ff;
      m_in    = m_ff;
      q1_in   = q1_ff;
      big_in  = big_ff;
      pos_in  = pos_ff;
      vel_in  = vel_ff;
      acc_in  = acc_ff;
      mul_a   = '0;
      mul_b   = '0;
      div_req = '0;
      cordic_start = 1'b0;
      cordic_z     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hp_in  = (hp_cfg_ff == '0) ? HP_W'(1) : hp_cfg_ff;
               sum_in = cycle_time_ff + {1'b0, req_time_step};
            end
         end
         ST_MOD_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = {sum_ff, 31'd0};
            div_req.divisor  = {hp_ff, 1'b0};
            div_req.steps    = STEPS_MOD;
         end
         ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               cycle_time_in = {1'b0, div_rsp.remainder};
            end
         end
         ST_PHASE: begin
            back_in          = back_c;
            div_req.start    = 1'b1;
            div_req.dividend = {tau_c[30:0], 33'd0};
            div_req.divisor  = {1'b0, hp_ff};
            div_req.steps    = STEPS_FRAC;
         end
         ST_FRAC_WAIT: begin
            // The phase fraction lies in [0, 1.0] of Q2.30; center it on zero.
            g_c     = {2'b00, q_c[30:0]} - {3'b000, HALF_Q30};
            gneg_in = g_c[32];
            mag_in  = g_c[32] ? 30'(-g_c) : g_c[29:0];
         end
         ST_TH_MUL: begin
            mul_a = {2'b00, mag_ff};
            mul_b = PI_Q30;
         end
         ST_TH_RND: begin
            rnd_c        = round_shift(prod_ff, 30);
            th_c         = rnd_c[31:0];
            cordic_start = 1'b1;
            cordic_z     = gneg_ff ? -signed'({2'b00, th_c}) : signed'({2'b00, th_c});
         end
         ST_CORDIC_WAIT: begin
            if (cordic_done) begin
               sin_in  = clamp_unit(cordic_x);
               cos_in  = -clamp_unit(cordic_y);
               axis_in = 2'd0;
            end
         end
         ST_AX_DIFF: begin
            d_c   = {end_ff[axis_ff][31], end_ff[axis_ff]}
                  - {start_ff[axis_ff][31], start_ff[axis_ff]};
            dn_in = d_c[32];
            dm_in = d_c[32] ? 32'(-d_c) : d_c[31:0];
         end
         ST_POS_MUL: begin
            omc_c = 33'h0_4000_0000 - {cos_ff[31], cos_ff};
            mul_a = dm_ff;
            mul_b = omc_c[31:0];
         end
         ST_POS_RND: begin
            rnd_c = round_shift(prod_ff, 31);
            sm_c  = dn_ff ? -signed'({2'b00, rnd_c[32:0]}) : signed'({2'b00, rnd_c[32:0]});
            if (back_ff) begin
               p_c = {{3{end_ff[axis_ff][31]}}, end_ff[axis_ff]} - sm_c;
            end else begin
               p_c = {{3{start_ff[axis_ff][31]}}, start_ff[axis_ff]} + sm_c;
            end
            if (p_c > 35'sh0_7FFF_FFFF) begin
               pos_in[axis_ff] = 32'sh7FFF_FFFF;
            end else if (p_c < -35'sh0_8000_0000) begin
               pos_in[axis_ff] = 32'sh8000_0000;
            end else begin
               pos_in[axis_ff] = p_c[31:0];
            end
         end
         ST_VEL_MUL1: begin
            mul_a = dm_ff;
            mul_b = sin_ff[31] ? 32'(-sin_ff) : sin_ff;
         end
         ST_VEL_RND1, ST_ACC_RND1: begin
            rnd_c = round_shift(prod_ff, 30);
            m_in  = rnd_c[35:0];
         end
         ST_VEL_MUL2: begin
            mul_a = m_ff[31:0];
            mul_b = PI_Q30;
         end
         ST_VEL_RND2: begin
            rnd_c = round_shift(prod_ff, 30);
            m_in  = rnd_c[35:0];
         end
         ST_VEL_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = (64'(m_ff) << FRAC_BITS) + 64'(hp_ff);
            div_req.divisor  = {hp_ff, 1'b0};
            div_req.steps    = STEPS_FULL;
         end
         ST_VEL_WAIT: begin
            if (div_rsp.done) begin
               neg_c = dn_ff ^ sin_ff[31] ^ back_ff;
               vel_in[axis_ff] = sat_mag(neg_c, q_c, 1'b0);
            end
         end
         ST_ACC_MUL1: begin
            mul_a = dm_ff;
            mul_b = cos_ff[31] ? 32'(-cos_ff) : cos_ff;
         end
         ST_ACC_MUL2: begin
            mul_a = m_ff[31:0];
            mul_b = PI2_Q28;
         end
         ST_ACC_RND2: begin
            rnd_c = round_shift(prod_ff, 28);
            m_in  = rnd_c[35:0];
         end
         ST_ACC_DIV1: begin
            div_req.start    = 1'b1;
            div_req.dividend = (64'(m_ff) << FRAC_BITS) + 64'(hp_ff >> 1);
            div_req.divisor  = {1'b0, hp_ff};
            div_req.steps    = STEPS_FULL;
         end
         ST_ACC_WAIT1: begin
            if (div_rsp.done) begin
               // A first quotient this large always saturates the final result,
               // and a still larger one would overflow the second dividend.
               q1_in  = q_c;
               big_in = (q_c >> (63 - FRAC_BITS)) != '0;
            end
         end
         ST_ACC_DIV2: begin
            div_req.start    = 1'b1;
            div_req.dividend = (q1_ff << FRAC_BITS) + 64'(hp_ff);
            div_req.divisor  = {hp_ff, 1'b0};
            div_req.steps    = STEPS_FULL;
         end
         ST_ACC_WAIT2: begin
            if (div_rsp.done) begin
               neg_c = dn_ff ^ cos_ff[31] ^ back_ff;
               acc_in[axis_ff] = sat_mag(neg_c, q_c, big_ff);
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cycle_time_ff <= '0;
         start_ff[0]   <= '0;
         start_ff[1]   <= '0;
         start_ff[2]   <= '0;
         end_ff[0]     <= 32'sd65536;
         end_ff[1]     <= '0;
         end_ff[2]     <= '0;
         hp_cfg_ff     <= 31'd131072;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cycle_time_ff <= cycle_time_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_START_X:     start_ff[0] <= csr_wdata;
               REG_START_Y:     start_ff[1] <= csr_wdata;
               REG_START_Z:     start_ff[2] <= csr_wdata;
               REG_END_X:       end_ff[0]   <= csr_wdata;
               REG_END_Y:       end_ff[1]   <= csr_wdata;
               REG_END_Z:       end_ff[2]   <= csr_wdata;
               REG_HALF_PERIOD: hp_cfg_ff   <= csr_wdata[HP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hp_ff   <= hp_in;
      sum_ff  <= sum_in;
      back_ff <= back_in;
      mag_ff  <= mag_in;
      gneg_ff <= gneg_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
      axis_ff <= axis_in;
      dm_ff   <= dm_in;
      dn_ff   <= dn_in;
      m_ff    <= m_in;
      q1_ff   <= q1_in;
      big_ff  <= big_in;
      prod_ff <= mul_a * mul_b;
      pos_ff  <= pos_in;
      vel_ff  <= vel_in;
      acc_ff  <= acc_in;
      if (load_out) begin
         out_pos_ff <= pos_ff;
         out_vel_ff <= vel_ff;
         out_acc_ff <= acc_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = out_pos_ff[0];
   assign rsp_pos_y = out_pos_ff[1];
   assign rsp_pos_z = out_pos_ff[2];
   assign rsp_vel_x = out_vel_ff[0];
   assign rsp_vel_y = out_vel_ff[1];
   assign rsp_vel_z = out_vel_ff[2];
   assign rsp_acc_x = out_acc_ff[0];
   assign rsp_acc_y = out_acc_ff[1];
   assign rsp_acc_z = out_acc_ff[2];

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PHASE) |-> (cycle_time_ff < {1'b0, hp_ff, 1'b0}))
      else $error("cycle time not reduced below twice the half period");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAC_WAIT && div_rsp.done) |-> (div_rsp.quotient <= 64'h4000_0000))
      else $error("phase fraction above one");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result presented outside the final state");

endmodule

`default_nettype wire

// ===== tb/cmp3_checker.sv =====
// Checker for the cosine motion profile block: predicts each result and compares it.
`default_nettype none

module cmp3_checker import cmp3_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [IDX_CFG_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_wdata,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [TIME_W-1:0]    req_time_step,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [COORD_W-1:0]   rsp_pos_x,
   input  wire logic [COORD_W-1:0]   rsp_pos_y,
   input  wire logic [COORD_W-1:0]   rsp_pos_z,
   input  wire logic [COORD_W-1:0]   rsp_vel_x,
   input  wire logic [COORD_W-1:0]   rsp_vel_y,
   input  wire logic [COORD_W-1:0]   rsp_vel_z,
   input  wire logic [COORD_W-1:0]   rsp_acc_x,
   input  wire logic [COORD_W-1:0]   rsp_acc_y,
   input  wire logic [COORD_W-1:0]   rsp_acc_z,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [8:0][31:0] motion_t;

   localparam longint unsigned PI_FIX   = 64'd3373259426;
   localparam longint unsigned PI2_FIX  = 64'd2649351758;
   localparam longint          UNIT_FIX = 64'sd1073741824;
   localparam longint          GAIN_FIX = 64'sd652032874;
   localparam longint unsigned MAG_CAP  = 64'd1 << 62;
   localparam int              ROT_STEPS = 16;

   localparam longint ARC_TAB [16] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

   string field_name [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                             "acc_x", "acc_y", "acc_z"};

   longint          start_pt [3];
   longint          end_pt [3];
   longint unsigned half_per;
   longint unsigned cyc_time;
   motion_t         motion_q [$];

   assign pending = motion_q.size();

   function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b,
                                                 int s);
      return (a * b + (64'd1 << (s - 1))) >> s;
   endfunction

   function automatic longint unsigned div_round(longint unsigned m, longint unsigned den);
      longint unsigned hi, rm;
      hi = m / den;
      rm = m % den;
      if (hi >= (64'd1 << 32)) return MAG_CAP;
      return (hi << 16) + ((rm << 16) + den / 2) / den;
   endfunction

   function automatic logic [31:0] sat_word(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic logic [31:0] sat_signed_mag(bit neg, longint unsigned m);
      if (neg) return (m > 64'd2147483648) ? 32'h8000_0000 : sat_word(-longint'(m));
      return (m > 64'd2147483647) ? 32'h7FFF_FFFF : sat_word(longint'(m));
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > UNIT_FIX) return UNIT_FIX;
      if (v < -UNIT_FIX) return -UNIT_FIX;
      return v;
   endfunction

   function automatic motion_t predict_motion(logic [31:0] step);
      longint unsigned hp, tau, frac, mag, th, dm, m;
      longint          g, x, y, z, xs, ys, sin_t, cos_t, d, sm, p;
      bit              back, dn, neg;
      motion_t         r;
      hp = (half_per == 0) ? 64'd1 : half_per;
      cyc_time = (cyc_time + longint'(step)) % (2 * hp);
      back = cyc_time > hp;
      tau = back ? cyc_time - hp : cyc_time;
      frac = (tau << 30) / hp;
      g = longint'(frac) - 64'sd536870912;
      mag = (g < 0) ? -g : g;
      th = (mag * PI_FIX + 64'd536870912) >> 30;
      z = (g < 0) ? -longint'(th) : longint'(th);
      x = GAIN_FIX;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ARC_TAB[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ARC_TAB[i];
         end
      end
      // The rotation angle is offset by a quarter turn, so the outputs swap roles.
      sin_t = clamp_unit(x);
      cos_t = -clamp_unit(y);
      for (int k = 0; k < 3; k++) begin
         d = end_pt[k] - start_pt[k];
         dn = d < 0;
         dm = dn ? -d : d;
         m = mul_round(dm, longint'(UNIT_FIX - cos_t), 31);
         sm = dn ? -longint'(m) : longint'(m);
         p = back ? end_pt[k] - sm : start_pt[k] + sm;
         r[k] = sat_word(p);
         neg = dn ^ (sin_t < 0) ^ back;
         m = mul_round(dm, (sin_t < 0) ? -sin_t : sin_t, 30);
         m = mul_round(m, PI_FIX, 30);
         r[3 + k] = sat_signed_mag(neg, div_round(m, 2 * hp));
         neg = dn ^ (cos_t < 0) ^ back;
         m = mul_round(dm, (cos_t < 0) ? -cos_t : cos_t, 30);
         m = mul_round(m, PI2_FIX, 28);
         m = div_round(div_round(m, hp), 2 * hp);
         r[6 + k] = sat_signed_mag(neg, m);
      end
      return r;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      motion_t want, got;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            start_pt[k] = 0;
            end_pt[k] = 0;
         end
         end_pt[0] = 65536;
         half_per = 131072;
         cyc_time = 0;
         motion_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_START_X, REG_START_Y, REG_START_Z:
                  start_pt[csr_index - REG_START_X] = longint'($signed(csr_wdata));
               REG_END_X, REG_END_Y, REG_END_Z:
                  end_pt[csr_index - REG_END_X] = longint'($signed(csr_wdata));
               REG_HALF_PERIOD: half_per = longint'(csr_wdata[30:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready) motion_q.push_back(predict_motion(req_time_step));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_acc_z, rsp_acc_y, rsp_acc_x, rsp_vel_z, rsp_vel_y, rsp_vel_x,
                   rsp_pos_z, rsp_pos_y, rsp_pos_x};
            if (motion_q.size() == 0) begin
               $display("%0t: unexpected result transfer, actual %h", $time, got);
               fail_count++;
            end else begin
               want = motion_q.pop_front();
               for (int f = 0; f < 9; f++) begin
                  if (want[f] !== got[f]) begin
                     $display("%0t: %s mismatch, expected %h actual %h", $time,
                              field_name[f], want[f], got[f]);
                     fail_count++;
                  end
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_cosine_motion_profile_3axis_unit.sv =====
// Testbench top for the cosine motion profile block: stimulus, receiver stalls and verdict.
`default_nettype none

module tb_cosine_motion_profile_3axis_unit;
   import cmp3_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [IDX_CFG_W-1:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 48;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [IDX_CFG_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TIME_W-1:0]    req_time_step = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
   int fail_count, pending;
   int cycle_count = 0;
   int burst_left = 1;
   logic [30:0] cur_hp = 31'd131072;

   always #4 clock = ~clock;

   cosine_motion_profile_3axis_unit u_dut (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_time_step, .rsp_valid, .rsp_ready,
      .rsp_pos_x(pos_x), .rsp_pos_y(pos_y), .rsp_pos_z(pos_z),
      .rsp_vel_x(vel_x), .rsp_vel_y(vel_y), .rsp_vel_z(vel_z),
      .rsp_acc_x(acc_x), .rsp_acc_y(acc_y), .rsp_acc_z(acc_z));

   cmp3_checker u_checker (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_time_step, .rsp_valid, .rsp_ready,
      .rsp_pos_x(pos_x), .rsp_pos_y(pos_y), .rsp_pos_z(pos_z),
      .rsp_vel_x(vel_x), .rsp_vel_y(vel_y), .rsp_vel_z(vel_z),
      .rsp_acc_x(acc_x), .rsp_acc_y(acc_y), .rsp_acc_z(acc_z),
      .fail_count, .pending);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: changing ready patterns, plus one long hold-off to back up the block.
   initial begin
      int mode, mode_left, hold_left, rsp_seen;
      bit held;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_seen = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) rsp_seen++;
         if (!held && rsp_seen == 30) begin
            held = 1;
            hold_left = 6000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_step(input logic [31:0] v);
      int gap;
      req_valid <= 1'b1;
      req_time_step <= v;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 900) : $urandom_range(0, 5);
         req_valid <= 1'b0;
         repeat (gap + 1) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   // Lowers valid and waits until every transfer sent so far has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_profile(input logic [31:0] sx, sy, sz, ex, ey, ez, input logic [30:0] hp);
      logic [31:0] vals [7];
      vals = '{sx, sy, sz, ex, ey, ez, {1'b0, hp}};
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= REG_START_X + IDX_CFG_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // A write to the unused index must not disturb anything.
      csr_index <= REG_UNUSED;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cur_hp = hp;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return $urandom;
         default: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
      endcase
   endfunction

   function automatic logic [30:0] rand_hp();
      case ($urandom_range(0, 5))
         0: return 31'($urandom_range(0, 3));
         1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
         2: return 31'($urandom);
         default: return 31'($urandom_range(256, 1 << 20));
      endcase
   endfunction

   initial begin
      logic [31:0] steps [$];
      logic [31:0] span;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults: walk past the half period into the return leg, then wrap around.
      steps = '{32'd0, 32'd1, 32'd32767, 32'd65536, 32'd65536, 32'd1, 32'hFFFF_FFFF,
                32'd131071};
      foreach (steps[i]) send_step(steps[i]);
      drain();

      // Full-range travel with the shortest half period saturates the accelerations.
      set_profile(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1);
      steps = '{32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF};
      foreach (steps[i]) send_step(steps[i]);
      drain();

      set_profile(32'h7FFF_FFFF, 32'd0, 32'h8000_0000,
                  32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      steps = '{32'h3FFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
      foreach (steps[i]) send_step(steps[i]);
      drain();

      // A zero half period behaves as one.
      set_profile(32'd100, 32'hFFFF_0000, 32'd0, 32'd0, 32'd65536, 32'd7, 31'd0);
      steps = '{32'd0, 32'd1, 32'd2, 32'd5};
      foreach (steps[i]) send_step(steps[i]);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         // The cycle time carries over, so each new half period starts mid-run.
         set_profile(rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_hp());
         span = (cur_hp == 0) ? 32'd1 : {1'b0, cur_hp};
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 4))
               0: send_step($urandom);
               1: send_step(32'($urandom_range(0, 3)));
               default: send_step($urandom_range(0, span / 3 + 1));
            endcase
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
